@@ hw/rtl/pse_pkg.sv @@
package pse_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int DATA_W      = 32;

  // operator codes
  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_POW = 3'd4;

  // token kinds
  localparam logic ACT_NUMBER   = 1'b0;
  localparam logic ACT_OPERATOR = 1'b1;

  // result status codes
  localparam logic [2:0] ST_BUSY         = 3'd0;
  localparam logic [2:0] ST_OK           = 3'd1;
  localparam logic [2:0] ST_UNDERFLOW    = 3'd2;
  localparam logic [2:0] ST_DIVZERO      = 3'd3;
  localparam logic [2:0] ST_OVERFLOW     = 3'd4;
  localparam logic [2:0] ST_LEFTOVER     = 3'd5;
  localparam logic [2:0] ST_ZERO_NEG_POW = 3'd6;

  typedef struct packed {
    logic              start;
    logic [2:0]        op;
    logic [DATA_W-1:0] a;   // second operand
    logic [DATA_W-1:0] b;   // first operand (old top)
  } alu_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] res;
  } alu_rsp_t;

endpackage

@@ hw/rtl/pse_ram.sv @@
module pse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

@@ hw/rtl/pse_alu.sv @@
module pse_alu (
  input  logic               clk,
  input  logic               rst_n,
  input  pse_pkg::alu_req_t  req,
  output pse_pkg::alu_rsp_t  rsp
);

  typedef enum logic [4:0] {
    A_IDLE = 5'b00001,
    A_MUL  = 5'b00010,
    A_DIV  = 5'b00100,
    A_FIX  = 5'b01000,
    A_POW  = 5'b10000
  } alu_state_t;

  alu_state_t state_r, state_nxt;
  logic        done_r, done_nxt;
  logic [31:0] res_r, res_nxt;
  logic [31:0] a_r, a_nxt, b_r, b_nxt;
  logic [31:0] rem_r, rem_nxt, quo_r, quo_nxt, den_r, den_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        neg_r, neg_nxt;
  logic [32:0] rem_sh;
  logic [32:0] rem_sub;
  logic [63:0] prod_ab, prod_acc, prod_sq;

  assign rem_sh   = {rem_r, quo_r[31]};
  assign rem_sub  = rem_sh - {1'b0, den_r};
  assign prod_ab  = a_r * b_r;       // a_r: multiplicand or accumulator
  assign prod_acc = a_r * res_r;     // res_r holds the running square
  assign prod_sq  = res_r * res_r;

  always_comb begin
    state_nxt = state_r;
    done_nxt  = 1'b0;
    res_nxt   = res_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    den_nxt   = den_r;
    cnt_nxt   = cnt_r;
    neg_nxt   = neg_r;
    unique case (state_r)
      A_IDLE: begin
        if (req.start) begin
          a_nxt = req.a;
          b_nxt = req.b;
          unique case (req.op)
            pse_pkg::OP_ADD: begin
              res_nxt  = req.a + req.b;
              done_nxt = 1'b1;
            end
            pse_pkg::OP_SUB: begin
              res_nxt  = req.a - req.b;
              done_nxt = 1'b1;
            end
            pse_pkg::OP_MUL: state_nxt = A_MUL;
            pse_pkg::OP_DIV: begin
              rem_nxt   = '0;
              quo_nxt   = req.a[31] ? (~req.a + 32'd1) : req.a;
              den_nxt   = req.b[31] ? (~req.b + 32'd1) : req.b;
              neg_nxt   = req.a[31] ^ req.b[31];
              cnt_nxt   = 5'd31;
              state_nxt = A_DIV;
            end
            default: begin
              if (req.b[31]) begin
                // negative exponent: only bases one and minus one survive
                if (req.a == 32'd1) begin
                  res_nxt = 32'd1;
                end else if (req.a == 32'hFFFF_FFFF) begin
                  res_nxt = req.b[0] ? 32'hFFFF_FFFF : 32'd1;
                end else begin
                  res_nxt = '0;
                end
                done_nxt = 1'b1;
              end else begin
                // a_r = accumulator, res_r = square, b_r = exponent
                a_nxt     = 32'd1;
                res_nxt   = req.a;
                state_nxt = A_POW;
              end
            end
          endcase
        end
      end
      A_MUL: begin
        res_nxt   = prod_ab[31:0];
        done_nxt  = 1'b1;
        state_nxt = A_IDLE;
      end
      A_DIV: begin
        if (!rem_sub[32]) begin
          rem_nxt = rem_sub[31:0];
          quo_nxt = {quo_r[30:0], 1'b1};
        end else begin
          rem_nxt = rem_sh[31:0];
          quo_nxt = {quo_r[30:0], 1'b0};
        end
        cnt_nxt = cnt_r - 5'd1;
        if (cnt_r == 5'd0) begin
          state_nxt = A_FIX;
        end
      end
      A_FIX: begin
        // floor: differing signs with a remainder round one further down
        if (neg_r) begin
          res_nxt = (rem_r != '0) ? ~quo_r : (~quo_r + 32'd1);
        end else begin
          res_nxt = quo_r;
        end
        done_nxt  = 1'b1;
        state_nxt = A_IDLE;
      end
      A_POW: begin
        if (b_r == '0) begin
          res_nxt   = a_r;
          done_nxt  = 1'b1;
          state_nxt = A_IDLE;
        end else begin
          if (b_r[0]) begin
            a_nxt = prod_acc[31:0];
          end
          res_nxt = prod_sq[31:0];
          b_nxt   = {1'b0, b_r[31:1]};
        end
      end
      default: state_nxt = A_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= A_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    res_r <= res_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
    cnt_r <= cnt_nxt;
    neg_r <= neg_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.res  = res_r;

`ifndef SYNTHESIS
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r)
    else $error("alu done held longer than one cycle");
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> state_r == A_IDLE)
    else $error("alu started while busy");
`endif

endmodule

@@ hw/rtl/postfix_stack_evaluator.sv @@
// Postfix token evaluator. Each item is one token: tuser selects number (0) or
// operator (1), and the result of every token is one item on the output. A
// number push or an ignored token goes straight to the finish step; an operator
// that passes its checks goes through read, execute and finish, the operand
// below the top being read from the stack memory in the read step. Divide forms
// one quotient bit per cycle in the divider, and power one square-and-multiply
// step per cycle over the exponent bits. The stack holds STACK_DEPTH values; a
// new token is taken only after the previous result has been loaded into the output register.
module postfix_stack_evaluator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [31:0] number, [34:32] operator_code
  input  logic        in_tuser,   // [0] action
  input  logic        in_tlast,   // last_token
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] answer
  output logic [2:0]  out_tuser,  // [2:0] status
  output logic        out_tlast   // expression_done
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_EXEC = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic [pse_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [2:0]  err_r, err_nxt;
  logic [31:0] tos_r, tos_nxt;
  logic [2:0]  op_r, op_nxt;
  logic        last_r, last_nxt;
  logic        ovld_r, ovld_nxt;
  logic [31:0] odata_r, odata_nxt;
  logic [2:0]  ouser_r, ouser_nxt;
  logic        olast_r, olast_nxt;

  logic        accept;
  logic [31:0] in_number;
  logic [2:0]  in_op;
  logic [pse_pkg::CNT_W-1:0] cnt_m1, cnt_m2;
  logic        ram_we;
  logic [31:0] second;

  pse_pkg::alu_req_t alu_req;
  pse_pkg::alu_rsp_t alu_rsp;

  assign in_number = in_tdata[31:0];
  assign in_op     = in_tdata[34:32];
  assign in_tready = (state_r == S_IDLE) && (!ovld_r || out_tready);
  assign accept    = in_tvalid && in_tready;
  assign cnt_m1    = cnt_r - pse_pkg::CNT_W'(1);
  assign cnt_m2    = cnt_r - pse_pkg::CNT_W'(2);

  // tos lives in a register; the memory holds the values below it
  assign ram_we = accept && (err_r == pse_pkg::ST_BUSY) && (in_tuser == pse_pkg::ACT_NUMBER)
                  && (cnt_r < pse_pkg::CNT_W'(pse_pkg::STACK_DEPTH)) && (cnt_r != '0);

  pse_ram #(
    .WIDTH(pse_pkg::DATA_W),
    .DEPTH(pse_pkg::STACK_DEPTH)
  ) u_stack (
    .clk    (clk),
    .we     (ram_we),
    .waddr  (cnt_m1[pse_pkg::ADDR_W-1:0]),
    .wdata  (tos_r),
    .raddr  (cnt_m2[pse_pkg::ADDR_W-1:0]),
    .rdata_r(second)
  );

  pse_alu u_alu (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (alu_req),
    .rsp  (alu_rsp)
  );

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    err_nxt   = err_r;
    tos_nxt   = tos_r;
    op_nxt    = op_r;
    last_nxt  = last_r;
    ovld_nxt  = ovld_r && !out_tready;
    odata_nxt = odata_r;
    ouser_nxt = ouser_r;
    olast_nxt = olast_r;
    alu_req   = '{start: 1'b0, op: op_r, a: second, b: tos_r};
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt    = in_op;
          last_nxt  = in_tlast;
          state_nxt = S_FIN;
          if (err_r == pse_pkg::ST_BUSY) begin
            if (in_tuser == pse_pkg::ACT_NUMBER) begin
              if (cnt_r >= pse_pkg::CNT_W'(pse_pkg::STACK_DEPTH)) begin
                err_nxt = pse_pkg::ST_OVERFLOW;
              end else begin
                tos_nxt = in_number;
                cnt_nxt = cnt_r + pse_pkg::CNT_W'(1);
              end
            end else if (in_op <= pse_pkg::OP_POW) begin
              if (cnt_r < pse_pkg::CNT_W'(2)) begin
                err_nxt = pse_pkg::ST_UNDERFLOW;
              end else if (in_op == pse_pkg::OP_DIV && tos_r == '0) begin
                err_nxt = pse_pkg::ST_DIVZERO;
              end else begin
                state_nxt = S_READ;
              end
            end
          end
        end
      end
      S_READ: begin
        if (op_r == pse_pkg::OP_POW && tos_r[31] && second == '0) begin
          err_nxt   = pse_pkg::ST_ZERO_NEG_POW;
          state_nxt = S_FIN;
        end else begin
          alu_req.start = 1'b1;
          state_nxt     = S_EXEC;
        end
      end
      S_EXEC: begin
        if (alu_rsp.done) begin
          tos_nxt   = alu_rsp.res;
          cnt_nxt   = cnt_m1;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        ovld_nxt  = 1'b1;
        olast_nxt = last_r;
        odata_nxt = '0;
        if (err_r != pse_pkg::ST_BUSY) begin
          ouser_nxt = err_r;
        end else if (last_r) begin
          if (cnt_r == '0) begin
            ouser_nxt = pse_pkg::ST_UNDERFLOW;
          end else if (cnt_r == pse_pkg::CNT_W'(1)) begin
            ouser_nxt = pse_pkg::ST_OK;
            odata_nxt = tos_r;
          end else begin
            ouser_nxt = pse_pkg::ST_LEFTOVER;
            odata_nxt = 32'hFFFF_FFFF;
          end
        end else begin
          ouser_nxt = pse_pkg::ST_BUSY;
          if (cnt_r != '0) begin
            odata_nxt = tos_r;
          end
        end
        if (last_r) begin
          cnt_nxt = '0;
          err_nxt = pse_pkg::ST_BUSY;
        end
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      err_r   <= pse_pkg::ST_BUSY;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      err_r   <= err_nxt;
      ovld_r  <= ovld_nxt;
    end
    tos_r   <= tos_nxt;
    op_r    <= op_nxt;
    last_r  <= last_nxt;
    odata_r <= odata_nxt;
    ouser_r <= ouser_nxt;
    olast_r <= olast_nxt;
  end

  assign out_tvalid = ovld_r;
  assign out_tdata  = odata_r;
  assign out_tuser  = ouser_r;
  assign out_tlast  = olast_r;

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= pse_pkg::CNT_W'(pse_pkg::STACK_DEPTH))
    else $error("stack count beyond depth");
  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == S_FIN))
    else $error("result loaded outside finish step");
  a_done_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
    alu_rsp.done |-> state_r == S_EXEC)
    else $error("alu result with no operator pending");
`endif

endmodule
